@@ rtl/core/bank_controller_with_realtime_clock_assert.svh @@
// Assertion macros for the bank controller
`ifndef BANK_CONTROLLER_WITH_REALTIME_CLOCK_ASSERT_SVH
`define BANK_CONTROLLER_WITH_REALTIME_CLOCK_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every edge out of reset
`define BCRTC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bank controller: property violated");

// condition must never be seen out of reset
`define BCRTC_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("bank controller: forbidden condition seen");

`else

`define BCRTC_ASSERT(name, clk, rst, prop)
`define BCRTC_NEVER(name, clk, rst, cond)

`endif

`endif

@@ rtl/core/bcrtc_pkg.sv @@
package bcrtc_pkg;

   // item kinds carried on the request tuser
   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   // bus regions, address bits 15:13
   localparam logic [2:0] REGION_ENABLE   = 3'd0;
   localparam logic [2:0] REGION_ROM_BANK = 3'd1;
   localparam logic [2:0] REGION_SELECT   = 3'd2;
   localparam logic [2:0] REGION_LATCH    = 3'd3;
   localparam logic [2:0] REGION_RAM      = 3'd5;

   // bank / clock register select codes
   localparam logic [3:0] SEL_RAM_LIMIT = 4'd4;
   localparam logic [3:0] SEL_SECONDS   = 4'd8;
   localparam logic [3:0] SEL_MINUTES   = 4'd9;
   localparam logic [3:0] SEL_HOURS     = 4'd10;
   localparam logic [3:0] SEL_DAYS_LOW  = 4'd11;
   localparam logic [3:0] SEL_DAYS_HIGH = 4'd12;

   // clock flag bits
   localparam int FLAG_DAY_MSB = 0;
   localparam int FLAG_HALT    = 1;
   localparam int FLAG_CARRY   = 2;

   localparam logic [7:0] ENABLE_MASK  = 8'h0A;
   localparam logic [7:0] BYTE_INVALID = 8'hFF;
   localparam logic [6:0] ROM_BANK_MASK = 7'h7F;

   // save RAM geometry
   localparam int RAM_BANKS  = 4;
   localparam int BANK_BYTES = 8192;
   localparam int BANK_AW    = $clog2(BANK_BYTES);
   localparam int RAM_DEPTH  = RAM_BANKS * BANK_BYTES;
   localparam int RAM_AW     = $clog2(RAM_DEPTH);

   // seconds divide by 60: sec < 2^17, q = (sec * SEC_RECIP) >> SEC_SHIFT
   localparam logic [17:0] SEC_RECIP = 18'd139811;
   localparam int          SEC_SHIFT = 23;

   // bounds of the carry chain
   localparam int SEC_SUM_MAX = 255 + 65536;
   localparam int SEC_QUO_MAX = SEC_SUM_MAX / 60;
   localparam int MIN_SUM_MAX = 255 + SEC_QUO_MAX;
   localparam int MIN_QUO_MAX = MIN_SUM_MAX / 60;
   localparam int HRS_SUM_MAX = 255 + MIN_QUO_MAX;
   localparam int HRS_QUO_MAX = HRS_SUM_MAX / 24;

endpackage

@@ rtl/core/bank_controller_with_realtime_clock.sv @@
// Path: a read or write item is held in the input stage register, then its result in the result register;
// a tick also waits in the input stage while the divide-by-60 multiply of tick step one is registered
// ahead of the carry stage. One read or write item per cycle while the result register is free.
// Reset: synchronous, active high; resets control, bank and clock state, then sweeps the
// 32768-byte save RAM to zero one byte per cycle with req_tready low.
`include "bank_controller_with_realtime_clock_assert.svh"

module bank_controller_with_realtime_clock (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // address[15:0], data_in[23:16], elapsed[55:24]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_data[7:0], rom_byte_address[28:8], zero[31:29]
   output logic [0:0]  rsp_tuser    // from_rom[0]
);
   import bcrtc_pkg::*;

   // input stage
   logic        item_valid_ff, item_valid_in;
   logic [1:0]  item_cmd_ff, item_cmd_in;
   logic [15:0] item_addr_ff, item_addr_in;
   logic [7:0]  item_data_ff, item_data_in;
   logic [31:0] item_elapsed_ff, item_elapsed_in;

   // tick first step
   logic        tick_phase_ff, tick_phase_in;
   logic [16:0] tick_sec_ff, tick_sec_in;
   logic [10:0] tick_quo_ff, tick_quo_in;
   logic [15:0] tick_frac_ff, tick_frac_in;

   // controller and clock state
   logic        ram_clock_en_ff, ram_clock_en_in;
   logic [6:0]  rom_bank_ff, rom_bank_in;
   logic [3:0]  bank_sel_ff, bank_sel_in;
   logic        latch_zero_ff, latch_zero_in;
   logic        snapshot_active_ff, snapshot_active_in;
   logic [34:0] clock_snapshot_ff, clock_snapshot_in;
   logic [7:0]  clock_seconds_ff, clock_seconds_in;
   logic [7:0]  clock_minutes_ff, clock_minutes_in;
   logic [7:0]  clock_hours_ff, clock_hours_in;
   logic [7:0]  clock_days_low_ff, clock_days_low_in;
   logic [2:0]  clock_flags_ff, clock_flags_in;
   logic [15:0] second_fraction_ff, second_fraction_in;

   // RAM clearing sweep
   logic              clr_busy_ff, clr_busy_in;
   logic [RAM_AW-1:0] clr_addr_ff, clr_addr_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_read_ff, rsp_read_in;
   logic        rsp_rom_ff, rsp_rom_in;
   logic [20:0] rsp_rom_addr_ff, rsp_rom_addr_in;
   logic        rsp_ram_ff, rsp_ram_in;

   // save RAM
   logic [7:0]        save_ram_ff [RAM_DEPTH];
   logic [7:0]        ram_q_ff;
   logic              mem_we, mem_re;
   logic [RAM_AW-1:0] mem_waddr, mem_raddr, item_ram_addr;
   logic [7:0]        mem_wdata;

   // handshake and datapath
   logic        out_free, tick_held, tick_wait, item_go, accept;
   logic [34:0] clock_pack, clock_view;
   logic [32:0] frac_sum;
   logic [16:0] sec_sum, sec_full;
   logic [34:0] sec_prod;
   logic [10:0] min_sum, min_full;
   logic [4:0]  min_quo;
   logic [8:0]  hrs_sum, hrs_full;
   logic [3:0]  hrs_quo;
   logic [9:0]  days_sum;
   logic        ram_bank_ok;

   // packed live clock and the view seen by reads
   assign clock_pack = {clock_flags_ff, clock_days_low_ff, clock_hours_ff,
                        clock_minutes_ff, clock_seconds_ff};
   assign clock_view = snapshot_active_ff ? clock_snapshot_ff : clock_pack;

   assign item_ram_addr = RAM_AW'(int'(bank_sel_ff) * BANK_BYTES
                                  + int'(item_addr_ff[BANK_AW-1:0]));
   assign ram_bank_ok   = (bank_sel_ff < SEL_RAM_LIMIT) && (int'(bank_sel_ff) < RAM_BANKS);

   // tick step one: fraction add and seconds quotient by reciprocal multiply
   assign frac_sum = {17'd0, second_fraction_ff} + {1'b0, item_elapsed_ff};
   assign sec_sum  = 17'(clock_seconds_ff) + frac_sum[32:16];
   assign sec_prod = 35'(sec_sum) * 35'(SEC_RECIP);

   // tick step two: remainders and the minute, hour and day carries
   always_comb begin
      sec_full = tick_sec_ff - (17'(tick_quo_ff) * 17'd60);
      min_sum  = 11'(clock_minutes_ff) + tick_quo_ff;
      min_quo  = '0;
      for (int k = 1; k <= MIN_QUO_MAX; k++) begin
         if (min_sum >= 11'(60 * k)) begin
            min_quo = 5'(k);
         end
      end
      min_full = min_sum - (11'(min_quo) * 11'd60);
      hrs_sum  = 9'(clock_hours_ff) + 9'(min_quo);
      hrs_quo  = '0;
      for (int k = 1; k <= HRS_QUO_MAX; k++) begin
         if (hrs_sum >= 9'(24 * k)) begin
            hrs_quo = 4'(k);
         end
      end
      hrs_full = hrs_sum - (9'(hrs_quo) * 9'd24);
      days_sum = {1'b0, clock_flags_ff[FLAG_DAY_MSB], clock_days_low_ff} + 10'(hrs_quo);
   end

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign tick_held = item_valid_ff && (item_cmd_ff == CMD_TICK);
   assign tick_wait = tick_held && !tick_phase_ff;
   assign item_go   = item_valid_ff && out_free && !tick_wait;
   assign req_tready = !clr_busy_ff && (!item_valid_ff || item_go);
   assign accept     = req_tvalid && req_tready;

   // next state and execution of the item in the input stage
   always_comb begin
      item_valid_in      = item_valid_ff;
      item_cmd_in        = item_cmd_ff;
      item_addr_in       = item_addr_ff;
      item_data_in       = item_data_ff;
      item_elapsed_in    = item_elapsed_ff;
      tick_phase_in      = tick_phase_ff;
      tick_sec_in        = tick_sec_ff;
      tick_quo_in        = tick_quo_ff;
      tick_frac_in       = tick_frac_ff;
      ram_clock_en_in    = ram_clock_en_ff;
      rom_bank_in        = rom_bank_ff;
      bank_sel_in        = bank_sel_ff;
      latch_zero_in      = latch_zero_ff;
      snapshot_active_in = snapshot_active_ff;
      clock_snapshot_in  = clock_snapshot_ff;
      clock_seconds_in   = clock_seconds_ff;
      clock_minutes_in   = clock_minutes_ff;
      clock_hours_in     = clock_hours_ff;
      clock_days_low_in  = clock_days_low_ff;
      clock_flags_in     = clock_flags_ff;
      second_fraction_in = second_fraction_ff;
      clr_busy_in        = clr_busy_ff;
      clr_addr_in        = clr_addr_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_read_in        = rsp_read_ff;
      rsp_rom_in         = rsp_rom_ff;
      rsp_rom_addr_in    = rsp_rom_addr_ff;
      rsp_ram_in         = rsp_ram_ff;
      mem_we             = 1'b0;
      mem_waddr          = clr_addr_ff;
      mem_wdata          = '0;
      mem_re             = 1'b0;
      mem_raddr          = item_ram_addr;

      // zero sweep after reset
      if (clr_busy_ff) begin
         mem_we      = 1'b1;
         clr_addr_in = clr_addr_ff + RAM_AW'(1);
         if (clr_addr_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end

      // result register drains
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // tick step one
      if (tick_wait) begin
         tick_phase_in = 1'b1;
         tick_sec_in   = sec_sum;
         tick_quo_in   = sec_prod[SEC_SHIFT+10:SEC_SHIFT];
         tick_frac_in  = frac_sum[15:0];
      end

      if (item_go) begin
         item_valid_in   = 1'b0;
         tick_phase_in   = 1'b0;
         rsp_valid_in    = 1'b1;
         rsp_read_in     = '0;
         rsp_rom_in      = 1'b0;
         rsp_rom_addr_in = '0;
         rsp_ram_in      = 1'b0;
         case (item_cmd_ff)
            CMD_READ: begin
               if (!item_addr_ff[15]) begin
                  // ROM fetch, fixed bank 0 below 0x4000
                  rsp_rom_in      = 1'b1;
                  rsp_rom_addr_in = {item_addr_ff[14] ? rom_bank_ff : 7'd0,
                                     item_addr_ff[13:0]};
               end else if (item_addr_ff[15:13] == REGION_RAM) begin
                  if (!ram_clock_en_ff) begin
                     rsp_read_in = BYTE_INVALID;
                  end else if (bank_sel_ff < SEL_RAM_LIMIT) begin
                     if (ram_bank_ok) begin
                        mem_re     = 1'b1;
                        rsp_ram_in = 1'b1;
                     end else begin
                        rsp_read_in = BYTE_INVALID;
                     end
                  end else begin
                     case (bank_sel_ff)
                        SEL_SECONDS:   rsp_read_in = clock_view[7:0];
                        SEL_MINUTES:   rsp_read_in = clock_view[15:8];
                        SEL_HOURS:     rsp_read_in = clock_view[23:16];
                        SEL_DAYS_LOW:  rsp_read_in = clock_view[31:24];
                        SEL_DAYS_HIGH: rsp_read_in = {clock_view[32 + FLAG_CARRY],
                                                      clock_view[32 + FLAG_HALT], 5'd0,
                                                      clock_view[32 + FLAG_DAY_MSB]};
                        default:       rsp_read_in = BYTE_INVALID;
                     endcase
                  end
               end else begin
                  rsp_read_in = BYTE_INVALID;
               end
            end
            CMD_WRITE: begin
               case (item_addr_ff[15:13])
                  REGION_ENABLE: begin
                     ram_clock_en_in = (item_data_ff & ENABLE_MASK) != 8'd0;
                  end
                  REGION_ROM_BANK: begin
                     rom_bank_in = item_data_ff[6:0] & ROM_BANK_MASK;
                     if (rom_bank_in == 7'd0) begin
                        rom_bank_in = 7'd1;
                     end
                  end
                  REGION_SELECT: begin
                     bank_sel_in = item_data_ff[3:0];
                  end
                  REGION_LATCH: begin
                     // zero then one toggles the frozen copy
                     if (latch_zero_ff && item_data_ff == 8'd1) begin
                        snapshot_active_in = !snapshot_active_ff;
                        if (!snapshot_active_ff) begin
                           clock_snapshot_in = clock_pack;
                        end
                     end
                     latch_zero_in = item_data_ff == 8'd0;
                  end
                  REGION_RAM: begin
                     if (ram_clock_en_ff) begin
                        if (bank_sel_ff < SEL_RAM_LIMIT) begin
                           if (ram_bank_ok) begin
                              mem_we    = 1'b1;
                              mem_waddr = item_ram_addr;
                              mem_wdata = item_data_ff;
                           end
                        end else begin
                           case (bank_sel_ff)
                              SEL_SECONDS:   clock_seconds_in  = item_data_ff;
                              SEL_MINUTES:   clock_minutes_in  = item_data_ff;
                              SEL_HOURS:     clock_hours_in    = item_data_ff;
                              SEL_DAYS_LOW:  clock_days_low_in = item_data_ff;
                              SEL_DAYS_HIGH: clock_flags_in    = {item_data_ff[7],
                                                                  item_data_ff[6],
                                                                  item_data_ff[0]};
                              default:       clock_flags_in    = clock_flags_ff;
                           endcase
                        end
                     end
                  end
                  default: begin
                     bank_sel_in = bank_sel_ff;
                  end
               endcase
            end
            CMD_TICK: begin
               // tick step two: commit carries unless halted
               if (!clock_flags_ff[FLAG_HALT]) begin
                  second_fraction_in = tick_frac_ff;
                  clock_seconds_in   = 8'(sec_full[5:0]);
                  clock_minutes_in   = 8'(min_full[5:0]);
                  clock_hours_in     = 8'(hrs_full[4:0]);
                  clock_days_low_in  = days_sum[7:0];
                  clock_flags_in[FLAG_DAY_MSB] = days_sum[8];
                  if (days_sum[9]) begin
                     clock_flags_in[FLAG_CARRY] = 1'b1;
                  end
               end
            end
            default: begin
               rsp_read_in = '0;
            end
         endcase
      end

      // load a new item
      if (accept) begin
         item_valid_in   = 1'b1;
         item_cmd_in     = req_tuser;
         item_addr_in    = req_tdata[15:0];
         item_data_in    = req_tdata[23:16];
         item_elapsed_in = req_tdata[55:24];
      end
   end

   // control and clock registers
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff      <= 1'b0;
         tick_phase_ff      <= 1'b0;
         ram_clock_en_ff    <= 1'b0;
         rom_bank_ff        <= 7'd1;
         bank_sel_ff        <= '0;
         latch_zero_ff      <= 1'b0;
         snapshot_active_ff <= 1'b0;
         clock_snapshot_ff  <= '0;
         clock_seconds_ff   <= '0;
         clock_minutes_ff   <= '0;
         clock_hours_ff     <= '0;
         clock_days_low_ff  <= '0;
         clock_flags_ff     <= '0;
         second_fraction_ff <= '0;
         clr_busy_ff        <= 1'b1;
         clr_addr_ff        <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         item_valid_ff      <= item_valid_in;
         tick_phase_ff      <= tick_phase_in;
         ram_clock_en_ff    <= ram_clock_en_in;
         rom_bank_ff        <= rom_bank_in;
         bank_sel_ff        <= bank_sel_in;
         latch_zero_ff      <= latch_zero_in;
         snapshot_active_ff <= snapshot_active_in;
         clock_snapshot_ff  <= clock_snapshot_in;
         clock_seconds_ff   <= clock_seconds_in;
         clock_minutes_ff   <= clock_minutes_in;
         clock_hours_ff     <= clock_hours_in;
         clock_days_low_ff  <= clock_days_low_in;
         clock_flags_ff     <= clock_flags_in;
         second_fraction_ff <= second_fraction_in;
         clr_busy_ff        <= clr_busy_in;
         clr_addr_ff        <= clr_addr_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_cmd_ff     <= item_cmd_in;
      item_addr_ff    <= item_addr_in;
      item_data_ff    <= item_data_in;
      item_elapsed_ff <= item_elapsed_in;
      tick_sec_ff     <= tick_sec_in;
      tick_quo_ff     <= tick_quo_in;
      tick_frac_ff    <= tick_frac_in;
      rsp_read_ff     <= rsp_read_in;
      rsp_rom_ff      <= rsp_rom_in;
      rsp_rom_addr_ff <= rsp_rom_addr_in;
      rsp_ram_ff      <= rsp_ram_in;
   end

   // save RAM, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         save_ram_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         ram_q_ff <= save_ram_ff[mem_raddr];
      end
   end

   // result item
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_rom_addr_ff, rsp_ram_ff ? ram_q_ff : rsp_read_ff};
   assign rsp_tuser  = rsp_rom_ff;

   // checks
   `BCRTC_ASSERT(a_no_accept_in_clear, clock, reset, clr_busy_ff |-> !req_tready)
   `BCRTC_NEVER(a_rom_bank_nonzero, clock, reset, rom_bank_ff == 7'd0)
   `BCRTC_ASSERT(a_tick_phase_item, clock, reset, tick_phase_ff |-> tick_held)
   `BCRTC_ASSERT(a_ram_result_not_rom, clock, reset, (rsp_valid_ff && rsp_ram_ff) |-> !rsp_rom_ff)

endmodule
